@@ rtl/core/mono_framebuffer_draw_engine_assert.svh @@
// Assertion helpers for the checker file.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFDE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mfde_pkg.sv @@
package mfde_pkg;

   // Screen geometry and store size
   localparam int SCREEN_WIDTH = 400;
   localparam int SCREEN_LINES = 240;
   localparam int STORE_BYTES  = 12000;

   localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int YW = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PW = $clog2(SCREEN_WIDTH * SCREEN_LINES + 1);

   // Command queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic [3:0] CMD_PIXEL     = 4'd0;
   localparam logic [3:0] CMD_FILL      = 4'd1;
   localparam logic [3:0] CMD_OUTLINE   = 4'd2;
   localparam logic [3:0] CMD_HLINE     = 4'd3;
   localparam logic [3:0] CMD_VLINE     = 4'd4;
   localparam logic [3:0] CMD_CLEAR     = 4'd5;
   localparam logic [3:0] CMD_IMG_START = 4'd6;
   localparam logic [3:0] CMD_IMG_BYTE  = 4'd7;
   localparam logic [3:0] CMD_READ      = 4'd8;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_RECT,
      OP_OUTLINE,
      OP_CLEAR,
      OP_IMG_START,
      OP_IMG_BYTE,
      OP_READ
   } op_type;

   // Classified transaction as held in the queue
   typedef struct packed {
      op_type          op;
      logic            color;
      logic [XW-1:0]   xa;
      logic [XW-1:0]   xb;
      logic [YW-1:0]   ya;
      logic [YW-1:0]   yb;
      logic [9:0]      pos_x;
      logic [8:0]      pos_y;
      logic [9:0]      width;
      logic [8:0]      height;
      logic [7:0]      image_byte;
      logic [13:0]     read_address;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_status_type;

   function automatic logic [XW-1:0] clamp_x(input logic [10:0] x);
      if (x >= 11'(SCREEN_WIDTH)) begin
         return XW'(SCREEN_WIDTH - 1);
      end
      return x[XW-1:0];
   endfunction

   function automatic logic [YW-1:0] clamp_y(input logic [10:0] y);
      if (y >= 11'(SCREEN_LINES)) begin
         return YW'(SCREEN_LINES - 1);
      end
      return y[YW-1:0];
   endfunction

   // Byte index of a clamped pixel, normal or mirrored orientation
   function automatic logic [PW-1:0] pixel_index(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y,
                                                 input logic mirror);
      logic [PW-1:0] row;
      logic [PW-1:0] col;
      logic [PW-1:0] sum;
      row = mirror ? (PW'(SCREEN_LINES - 1) - PW'(y)) : PW'(y);
      col = mirror ? (PW'(SCREEN_WIDTH - 1) - PW'(x)) : PW'(x);
      sum = PW'(SCREEN_WIDTH) * row + col;
      return sum >> 3;
   endfunction

   function automatic logic [7:0] pixel_mask(input logic [2:0] xl, input logic mirror);
      return mirror ? (8'h80 >> xl) : (8'h01 << xl);
   endfunction

endpackage

@@ rtl/core/mfde_front.sv @@
module mfde_front import mfde_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [3:0]      req_cmd,
   input  logic [9:0]      req_pos_x,
   input  logic [8:0]      req_pos_y,
   input  logic [9:0]      req_shape_width,
   input  logic [8:0]      req_shape_height,
   input  logic [9:0]      req_line_length,
   input  logic            req_pixel_color,
   input  logic [7:0]      req_image_byte,
   input  logic [13:0]     req_read_address,
   input  back_status_type back_status,
   output queue_type       queue_head
);

   item_type         cls;
   item_type         q_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wptr_ff;
   logic [QPW-1:0]   rptr_ff;
   logic [QCW-1:0]   cnt_ff;
   logic [QCW-1:0]   cnt_in;
   logic             push;
   logic             pop;
   logic [10:0]      x_w;
   logic [10:0]      y_h;
   logic [10:0]      x_len;
   logic [10:0]      y_len;

   // Shape extents before clamping
   assign x_w   = 11'(req_pos_x) + 11'(req_shape_width);
   assign y_h   = 11'(req_pos_y) + 11'(req_shape_height);
   assign x_len = 11'(req_pos_x) + 11'(req_line_length);
   assign y_len = 11'(req_pos_y) + 11'(req_line_length);

   // Classify the command and work out clamped bounds
   always_comb begin
      cls.op           = OP_NOP;
      cls.color        = req_pixel_color;
      cls.xa           = clamp_x(11'(req_pos_x));
      cls.xb           = clamp_x(11'(req_pos_x));
      cls.ya           = clamp_y(11'(req_pos_y));
      cls.yb           = clamp_y(11'(req_pos_y));
      cls.pos_x        = req_pos_x;
      cls.pos_y        = req_pos_y;
      cls.width        = req_shape_width;
      cls.height       = req_shape_height;
      cls.image_byte   = req_image_byte;
      cls.read_address = req_read_address;
      case (req_cmd)
         CMD_PIXEL: begin
            cls.op = OP_RECT;
         end
         CMD_FILL: begin
            cls.op = (req_shape_width == 10'd0 || req_shape_height == 9'd0) ? OP_NOP : OP_RECT;
            cls.xb = clamp_x(x_w - 11'd1);
            cls.yb = clamp_y(y_h - 11'd1);
         end
         CMD_OUTLINE: begin
            cls.op = OP_OUTLINE;
            cls.xb = clamp_x(x_w);
            cls.yb = clamp_y(y_h);
         end
         CMD_HLINE: begin
            cls.op = OP_RECT;
            cls.xb = clamp_x(x_len);
         end
         CMD_VLINE: begin
            cls.op = OP_RECT;
            cls.yb = clamp_y(y_len);
         end
         CMD_CLEAR:     cls.op = OP_CLEAR;
         CMD_IMG_START: cls.op = OP_IMG_START;
         CMD_IMG_BYTE:  cls.op = OP_IMG_BYTE;
         CMD_READ:      cls.op = OP_READ;
         default:       cls.op = OP_NOP;
      endcase
   end

   // Queue control
   assign req_stall = (cnt_ff == QCW'(QUEUE_DEPTH)) || back_status.init_busy;
   assign push      = req_valid && !req_stall;
   assign pop       = back_status.pop && (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wptr_ff <= wptr_ff + QPW'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + QPW'(1);
         end
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

   assign queue_head.valid = (cnt_ff != '0);
   assign queue_head.item  = q_ff[rptr_ff];

endmodule

@@ rtl/core/mfde_exec.sv @@
module mfde_exec import mfde_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_type       queue_head,
   output back_status_type back_status,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_image_active
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PLOT_RD,
      S_PLOT_WR,
      S_SWEEP,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [XW-1:0] x0;
      logic [XW-1:0] x1;
      logic [YW-1:0] y0;
      logic [YW-1:0] y1;
   } rect_type;

   state_type      state_ff;
   item_type       it_ff;
   logic [1:0]     phase_ff;
   logic [XW-1:0]  cx_ff;
   logic [YW-1:0]  cy_ff;
   logic [2:0]     bit_ff;
   logic [AW-1:0]  sweep_ff;
   logic [7:0]     fill_ff;
   logic [AW-1:0]  idx_ff;
   logic [7:0]     mask_ff;
   logic           ok_ff;
   logic           mirror_ff;
   logic [9:0]     bcx_ff;
   logic [9:0]     bcy_ff;
   logic [9:0]     box_ff;
   logic [8:0]     boy_ff;
   logic [9:0]     bw_ff;
   logic [8:0]     bh_ff;
   logic [16:0]    bleft_ff;
   logic           brun_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_data_ff;
   logic           rsp_active_ff;
   logic [7:0]     frame_ff [STORE_BYTES];
   logic [7:0]     rdata_ff;

   rect_type       cur_rect;
   rect_type       nxt_rect;
   logic [XW-1:0]  plot_x;
   logic [YW-1:0]  plot_y;
   logic [PW-1:0]  pix_idx;
   logic           pix_ok;
   logic           pix_color;
   logic [7:0]     wr_data;
   logic [9:0]     ncx;
   logic           wrap;
   logic [9:0]     ncx_in;
   logic [9:0]     ncy_in;
   logic           blit_stop;
   logic [16:0]    bleft_in;
   logic           read_ok;
   logic [18:0]    img_px;
   logic [16:0]    img_bytes;
   logic           out_free;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [7:0]     mem_wd;
   logic [AW-1:0]  mem_ra;
   logic           is_blit;

   // Rectangle walked in each outline phase
   function automatic rect_type rect_for(input item_type it, input logic [1:0] ph);
      rect_type r;
      r.x0 = it.xa;
      r.x1 = it.xb;
      r.y0 = it.ya;
      r.y1 = it.yb;
      if (it.op == OP_OUTLINE) begin
         case (ph)
            2'd0:    r.y1 = it.ya;
            2'd1:    r.y0 = it.yb;
            2'd2:    r.x1 = it.xa;
            default: r.x0 = it.xb;
         endcase
      end
      return r;
   endfunction

   assign cur_rect = rect_for(it_ff, phase_ff);
   assign nxt_rect = rect_for(it_ff, phase_ff + 2'd1);
   assign is_blit  = (it_ff.op == OP_IMG_BYTE);

   // Pixel address and mask
   assign plot_x  = is_blit ? clamp_x(11'(box_ff) + 11'(bcx_ff)) : cx_ff;
   assign plot_y  = is_blit ? clamp_y(11'(boy_ff) + 11'(bcy_ff)) : cy_ff;
   assign pix_idx = pixel_index(plot_x, plot_y, mirror_ff);
   assign pix_ok  = 32'(pix_idx) < 32'(STORE_BYTES);

   assign pix_color = is_blit ? it_ff.image_byte[3'd7 - bit_ff] : it_ff.color;
   assign wr_data   = pix_color ? (rdata_ff & ~mask_ff) : (rdata_ff | mask_ff);

   // Blit cursor advance and stop test
   assign ncx       = bcx_ff + 10'd1;
   assign wrap      = (ncx == bw_ff);
   assign ncx_in    = wrap ? 10'd0 : ncx;
   assign ncy_in    = wrap ? (bcy_ff + 10'd1) : bcy_ff;
   assign blit_stop = (ncy_in == 10'(bh_ff)) ||
                      ((11'(boy_ff) + 11'(ncy_in)) >= 11'(SCREEN_LINES));
   assign bleft_in  = (bleft_ff != 17'd0) ? (bleft_ff - 17'd1) : bleft_ff;

   assign read_ok   = 32'(it_ff.read_address) < 32'(STORE_BYTES);
   assign img_px    = 19'(queue_head.item.width) * 19'(queue_head.item.height);
   assign img_bytes = 17'(img_px >> 3);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Store port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = sweep_ff;
      mem_wd = fill_ff;
      case (state_ff)
         S_INIT, S_SWEEP: mem_we = 1'b1;
         S_PLOT_WR: begin
            mem_we = ok_ff;
            mem_wa = idx_ff;
            mem_wd = wr_data;
         end
         default: mem_we = 1'b0;
      endcase
      mem_ra = (it_ff.op == OP_READ) ? it_ff.read_address[AW-1:0] : AW'(pix_idx);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_ff[mem_wa] <= mem_wd;
      end
      rdata_ff <= frame_ff[mem_ra];
   end

   assign back_status.pop       = (state_ff == S_IDLE) && queue_head.valid;
   assign back_status.init_busy = (state_ff == S_INIT);

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         fill_ff      <= 8'h00;
         mirror_ff    <= 1'b1;
         bcx_ff       <= '0;
         bcy_ff       <= '0;
         box_ff       <= '0;
         boy_ff       <= '0;
         bw_ff        <= '0;
         bh_ff        <= '0;
         bleft_ff     <= '0;
         brun_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         bit_ff       <= '0;
         ok_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mirror_ff <= csr_write_data;
         end
         // Response register: load on completion, drop once taken
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT, S_SWEEP: begin
               if (sweep_ff == AW'(STORE_BYTES - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= (state_ff == S_INIT) ? S_IDLE : S_DONE;
               end else begin
                  sweep_ff <= sweep_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (queue_head.valid) begin
                  it_ff    <= queue_head.item;
                  phase_ff <= '0;
                  bit_ff   <= '0;
                  cx_ff    <= queue_head.item.xa;
                  cy_ff    <= queue_head.item.ya;
                  case (queue_head.item.op)
                     OP_RECT, OP_OUTLINE: state_ff <= S_PLOT_RD;
                     OP_CLEAR: begin
                        fill_ff  <= queue_head.item.color ? 8'h00 : 8'hFF;
                        sweep_ff <= '0;
                        state_ff <= S_SWEEP;
                     end
                     OP_IMG_START: begin
                        box_ff   <= queue_head.item.pos_x;
                        boy_ff   <= queue_head.item.pos_y;
                        bw_ff    <= queue_head.item.width;
                        bh_ff    <= queue_head.item.height;
                        bcx_ff   <= '0;
                        bcy_ff   <= '0;
                        bleft_ff <= img_bytes;
                        brun_ff  <= (img_bytes != 17'd0);
                        state_ff <= S_DONE;
                     end
                     OP_IMG_BYTE: state_ff <= brun_ff ? S_PLOT_RD : S_DONE;
                     OP_READ:     state_ff <= S_READ;
                     default:     state_ff <= S_DONE;
                  endcase
               end
            end
            S_PLOT_RD: begin
               idx_ff   <= AW'(pix_idx);
               mask_ff  <= pixel_mask(plot_x[2:0], mirror_ff);
               ok_ff    <= pix_ok;
               state_ff <= S_PLOT_WR;
            end
            S_PLOT_WR: begin
               if (is_blit) begin
                  bcx_ff <= ncx_in;
                  bcy_ff <= ncy_in;
                  bit_ff <= bit_ff + 3'd1;
                  if (blit_stop || bit_ff == 3'd7) begin
                     bleft_ff <= bleft_in;
                     brun_ff  <= !blit_stop && (bleft_in != 17'd0);
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PLOT_RD;
                  end
               end else if (cx_ff != cur_rect.x1) begin
                  cx_ff    <= cx_ff + XW'(1);
                  state_ff <= S_PLOT_RD;
               end else if (cy_ff != cur_rect.y1) begin
                  cx_ff    <= cur_rect.x0;
                  cy_ff    <= cy_ff + YW'(1);
                  state_ff <= S_PLOT_RD;
               end else if (it_ff.op == OP_OUTLINE && phase_ff != 2'd3) begin
                  phase_ff <= phase_ff + 2'd1;
                  cx_ff    <= nxt_rect.x0;
                  cy_ff    <= nxt_rect.y0;
                  state_ff <= S_PLOT_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_READ: state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  rsp_data_ff   <= (it_ff.op == OP_READ && read_ok) ? rdata_ff : 8'h00;
                  rsp_active_ff <= brun_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_image_active = rsp_active_ff;

endmodule

@@ rtl/core/mono_framebuffer_draw_engine.sv @@
// Monochrome 1-bit-per-pixel drawing engine over a 12000-byte store. After reset the
// store is swept to zero with req_stall held high (csr writes are still taken). A front
// end classifies commands and clamps shape bounds into a two-entry queue; a back end walks
// them against the store (one read port, one write port) with a read-modify-write per
// pixel, in a read state followed by a write state; the store sets the pace.
module mono_framebuffer_draw_engine import mfde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_cmd,
   input  logic [9:0]  req_pos_x,
   input  logic [8:0]  req_pos_y,
   input  logic [9:0]  req_shape_width,
   input  logic [8:0]  req_shape_height,
   input  logic [9:0]  req_line_length,
   input  logic        req_pixel_color,
   input  logic [7:0]  req_image_byte,
   input  logic [13:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_image_active,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   queue_type       queue_head;
   back_status_type back_status;

   // Command intake and queue
   mfde_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_shape_width  (req_shape_width),
      .req_shape_height (req_shape_height),
      .req_line_length  (req_line_length),
      .req_pixel_color  (req_pixel_color),
      .req_image_byte   (req_image_byte),
      .req_read_address (req_read_address),
      .back_status      (back_status),
      .queue_head       (queue_head)
   );

   // Drawing sequencer and store
   mfde_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .queue_head       (queue_head),
      .back_status      (back_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_image_active (rsp_image_active)
   );

endmodule

@@ rtl/core/mfde_checker.sv @@
`include "mono_framebuffer_draw_engine_assert.svh"

module mfde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_image_active
);

   logic [3:0] pend_ff;
   logic       req_take;
   logic       rsp_take;
   logic [8:0] rsp_payload;

   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign rsp_payload = {rsp_read_data, rsp_image_active};

   // Transactions accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pend_ff <= pend_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pend_ff <= pend_ff - 4'd1;
      end
   end

   `MFDE_ASSERT_SAME(a_init_stall, $past(reset), req_stall, "intake open during store clear")
   `MFDE_ASSERT_SAME(a_no_extra_rsp, rsp_take, pend_ff != 4'd0, "response without transaction")
   `MFDE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);
